### design/ternary_weight_dot_saturate_top_defines.svh
// Assertion macros for the ternary dot product design; twds_merge includes them.
`ifndef TERNARY_WEIGHT_DOT_SATURATE_TOP_DEFINES_SVH
`define TERNARY_WEIGHT_DOT_SATURATE_TOP_DEFINES_SVH

// Check a property while out of reset.
`define TWDS_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define TWDS_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/twds_pkg.sv
`default_nettype none

package twds_pkg;

    localparam int ITEM_LANES = 4;
    localparam int ACT_W      = 31;
    localparam int CODE_W     = 2;
    localparam int LANE_CNT_W = 3;
    localparam int WEIGHT_W   = ITEM_LANES * CODE_W;
    // One negated activation needs one bit more than the activation.
    localparam int CONTRIB_W  = ACT_W + 1;
    // Sum of four contributions.
    localparam int TREE_W     = CONTRIB_W + 2;
    localparam int SUM_W      = 48;

    typedef logic signed [ACT_W-1:0]     act_t;
    typedef logic signed [CONTRIB_W-1:0] contrib_t;
    typedef logic signed [TREE_W-1:0]    tree_t;
    typedef logic signed [SUM_W-1:0]     sum_t;
    typedef logic signed [SUM_W:0]       acc_wide_t;
    typedef logic [CODE_W-1:0]           code_t;

    // Trit codes; the two other codes contribute nothing.
    localparam code_t CODE_PLUS  = 2'd1;
    localparam code_t CODE_MINUS = 2'd2;

    localparam sum_t SUM_LIMIT   = 48'sh7FFF_FFFF_FFFF;
    localparam sum_t CLAMP_LIMIT = 48'sd581130733;
    localparam act_t DOT_LIMIT   = 31'sd581130733;

    // Stage control passed between the lane stage and the merge stage.
    typedef struct packed {
        logic valid;
        logic last;
    } beat_t;

endpackage

`default_nettype wire

### design/twds_lane.sv
`default_nettype none

module twds_lane (
    input  wire logic                clk,
    input  wire logic                load,
    input  wire twds_pkg::act_t      act,
    input  wire twds_pkg::code_t     code,
    input  wire logic                used,
    output twds_pkg::contrib_t       contrib
);

    twds_pkg::contrib_t contrib_reg;
    twds_pkg::contrib_t contrib_next;
    twds_pkg::contrib_t act_ext;

    // Select +a, -a or zero from the trit code.
    always_comb
    begin
        act_ext      = twds_pkg::CONTRIB_W'(act);
        contrib_next = '0;
        if (used)
        begin
            unique case (code)
                twds_pkg::CODE_PLUS:  contrib_next = act_ext;
                twds_pkg::CODE_MINUS: contrib_next = -act_ext;
                default:              contrib_next = '0;
            endcase
        end
    end

    // Hold the lane contribution for the merge stage.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            contrib_reg <= contrib_next;
        end
    end

    assign contrib = contrib_reg;

endmodule

`default_nettype wire

### design/twds_merge.sv
`default_nettype none
`include "ternary_weight_dot_saturate_top_defines.svh"

module twds_merge (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire twds_pkg::beat_t         in_beat,
    input  wire logic [twds_pkg::ITEM_LANES-1:0][twds_pkg::CONTRIB_W-1:0] contrib,
    output logic                         in_ready,
    output logic                         out_valid,
    input  wire logic                    out_take,
    output twds_pkg::act_t               dot,
    output logic                         sat
);

    // Tree stage
    logic              s2_valid_reg, s2_valid_next;
    logic              s2_last_reg;
    twds_pkg::tree_t   tree_reg;
    twds_pkg::tree_t   tree_next;
    // Accumulator
    twds_pkg::sum_t    run_reg, run_next;
    twds_pkg::acc_wide_t acc_wide;
    twds_pkg::sum_t    acc_sat;
    // Finished cell sum
    logic              fin_valid_reg, fin_valid_next;
    twds_pkg::sum_t    fin_sum_reg;
    // Output register
    logic              out_valid_reg, out_valid_next;
    twds_pkg::act_t    dot_reg, dot_next;
    logic              sat_reg, sat_next;

    logic s2_take, s2_ready, s2_load, fin_ready, fin_take, out_ready;

    // Handshake chain from the output back to the lane stage.
    assign out_ready = !out_valid_reg || out_take;
    assign fin_ready = !fin_valid_reg || out_ready;
    assign fin_take  = fin_valid_reg && out_ready;
    assign s2_take   = s2_valid_reg && (!s2_last_reg || fin_ready);
    assign s2_ready  = !s2_valid_reg || s2_take;
    assign s2_load   = in_beat.valid && s2_ready;
    assign in_ready  = s2_ready;

    // Add the lane contributions.
    always_comb
    begin
        tree_next = '0;
        for (int n = 0; n < twds_pkg::ITEM_LANES; n++)
        begin
            tree_next = tree_next + twds_pkg::TREE_W'($signed(contrib[n]));
        end
    end

    // Accumulate with saturation at the accumulator limit.
    always_comb
    begin
        acc_wide = twds_pkg::acc_wide_t'(run_reg) + twds_pkg::acc_wide_t'(tree_reg);
        if (acc_wide > twds_pkg::acc_wide_t'(twds_pkg::SUM_LIMIT))
        begin
            acc_sat = twds_pkg::SUM_LIMIT;
        end
        else if (acc_wide < -twds_pkg::acc_wide_t'(twds_pkg::SUM_LIMIT))
        begin
            acc_sat = -twds_pkg::SUM_LIMIT;
        end
        else
        begin
            acc_sat = acc_wide[twds_pkg::SUM_W-1:0];
        end
    end

    // Clamp the finished sum and flag the clamp.
    always_comb
    begin
        if (fin_sum_reg > twds_pkg::CLAMP_LIMIT)
        begin
            dot_next = twds_pkg::DOT_LIMIT;
            sat_next = 1'b1;
        end
        else if (fin_sum_reg < -twds_pkg::CLAMP_LIMIT)
        begin
            dot_next = -twds_pkg::DOT_LIMIT;
            sat_next = 1'b1;
        end
        else
        begin
            dot_next = fin_sum_reg[twds_pkg::ACT_W-1:0];
            sat_next = 1'b0;
        end
    end

    // Next control state; drop non-last items after accumulation.
    always_comb
    begin
        s2_valid_next  = s2_ready ? in_beat.valid : s2_valid_reg;
        run_next       = run_reg;
        if (s2_take)
        begin
            run_next = s2_last_reg ? '0 : acc_sat;
        end
        fin_valid_next = fin_ready ? (s2_take && s2_last_reg) : fin_valid_reg;
        out_valid_next = out_ready ? fin_valid_reg : out_valid_reg;
    end

    // Advance control state and the accumulator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            run_reg       <= '0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            run_reg       <= run_next;
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load payload registers.
    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            tree_reg    <= tree_next;
            s2_last_reg <= in_beat.last;
        end
        if (s2_take && s2_last_reg)
        begin
            fin_sum_reg <= acc_sat;
        end
        if (fin_take)
        begin
            dot_reg <= dot_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign dot       = dot_reg;
    assign sat       = sat_reg;

    `TWDS_ASSERT(a_run_range, clk, rst_n, (run_reg <= twds_pkg::SUM_LIMIT) && (run_reg >= -twds_pkg::SUM_LIMIT), "accumulator beyond its limit")
    `TWDS_ASSERT(a_clear_after_last, clk, rst_n, (s2_take && s2_last_reg) |=> (run_reg == '0), "accumulator not cleared after last item")
    `TWDS_ASSERT(a_dot_range, clk, rst_n, out_valid_reg |-> ((dot_reg <= twds_pkg::DOT_LIMIT) && (dot_reg >= -twds_pkg::DOT_LIMIT)), "result outside clamp range")
    `TWDS_ASSERT(a_sat_at_limit, clk, rst_n, (out_valid_reg && sat_reg) |-> ((dot_reg == twds_pkg::DOT_LIMIT) || (dot_reg == -twds_pkg::DOT_LIMIT)), "saturated result not at limit")
    `TWDS_ASSERT(a_fin_hold, clk, rst_n, (fin_valid_reg && !out_ready) |=> fin_valid_reg, "finished sum lost while output stalled")

endmodule

`default_nettype wire

### design/ternary_weight_dot_saturate_top.sv
// Channel   Dir  Payload                                              Sideband
// s_*       in   tdata[135:0]: act0..act3, weight_byte, valid_lanes   tlast: last_element
// m_*       out  tdata[31:0]:  dot_value                              tuser: saturated
//
// One item is accepted per cycle while s_tready is high; a last item flows through to m_tvalid.
// Stages: lane contribution register, lane adder tree, accumulator, clamp/output register.
// The accumulator add and saturate sets the loop rate of one item per cycle.
// Reset clears all valid flags and the accumulator.
// A stalled output holds the output, finished-sum and any last item; non-last items keep flowing.
`default_nettype none

module ternary_weight_dot_saturate_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // activation_0, activation_1, activation_2, activation_3, weight_byte, valid_lanes, pad
    input  wire logic [135:0]  s_tdata,
    input  wire logic          s_tlast,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // dot_value, pad
    output logic [31:0]        m_tdata,
    // saturated
    output logic               m_tuser
);

    localparam int WOFS = twds_pkg::ITEM_LANES * twds_pkg::ACT_W;
    localparam int LOFS = WOFS + twds_pkg::WEIGHT_W;

    logic                                    s1_valid_reg, s1_valid_next;
    logic                                    s1_last_reg;
    logic                                    s1_ready, s1_load, merge_ready;
    logic [twds_pkg::WEIGHT_W-1:0]           weight_byte;
    logic [twds_pkg::LANE_CNT_W-1:0]         valid_lanes;
    logic [twds_pkg::ITEM_LANES-1:0][twds_pkg::CONTRIB_W-1:0] contrib;
    twds_pkg::beat_t                         s1_beat;
    twds_pkg::act_t                          dot_value;

    assign weight_byte = s_tdata[WOFS +: twds_pkg::WEIGHT_W];
    assign valid_lanes = s_tdata[LOFS +: twds_pkg::LANE_CNT_W];

    // Accept a transaction when the lane stage is free or moving on.
    assign s1_ready = !s1_valid_reg || merge_ready;
    assign s1_load  = s_tvalid && s1_ready;
    assign s_tready = s1_ready;

    // One lane per activation; lanes at or above the count are ignored.
    for (genvar n = 0; n < twds_pkg::ITEM_LANES; n++)
    begin : g_lane
        twds_lane u_lane (
            .clk     (clk),
            .load    (s1_load),
            .act     (s_tdata[n*twds_pkg::ACT_W +: twds_pkg::ACT_W]),
            .code    (weight_byte[n*twds_pkg::CODE_W +: twds_pkg::CODE_W]),
            .used    (valid_lanes > twds_pkg::LANE_CNT_W'(n)),
            .contrib (contrib[n])
        );
    end

    // Track the lane stage.
    always_comb
    begin
        s1_valid_next = s1_ready ? s_tvalid : s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_last_reg <= s_tlast;
        end
    end

    assign s1_beat.valid = s1_valid_reg;
    assign s1_beat.last  = s1_last_reg;

    twds_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_beat   (s1_beat),
        .contrib   (contrib),
        .in_ready  (merge_ready),
        .out_valid (m_tvalid),
        .out_take  (m_tready),
        .dot       (dot_value),
        .sat       (m_tuser)
    );

    assign m_tdata = {1'b0, dot_value};

endmodule

`default_nettype wire
